// ===== hdl/pprq_pkg.sv =====
// ----------------------------------------------------------------------------
// pprq_pkg
// Shared codes and widths of the process priority ready queue.
// ----------------------------------------------------------------------------
package pprq_pkg;

  localparam int ID_W   = 8;
  localparam int PIN_W  = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef logic [STAT_W-1:0] status_t;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== hdl/pprq_if.sv =====
// ----------------------------------------------------------------------------
// pprq_in_if / pprq_out_if
// Request and result channels of the ready queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pprq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [pprq_pkg::ID_W-1:0]  proc_id;
  logic [pprq_pkg::PIN_W-1:0] proc_priority;

  modport source (output valid, req_type, proc_id, proc_priority, input ready);
  modport sink   (input valid, req_type, proc_id, proc_priority, output ready);
endinterface

interface pprq_out_if;
  logic                        valid;
  logic                        ready;
  logic [pprq_pkg::ID_W-1:0]   out_id;
  logic [pprq_pkg::PIN_W-1:0]  out_priority;
  pprq_pkg::status_t           status;
  logic [pprq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, out_id, out_priority, status, occupancy, input ready);
  modport sink   (input valid, out_id, out_priority, status, occupancy, output ready);
endinterface

// ===== hdl/pprq_ram.sv =====
// ----------------------------------------------------------------------------
// pprq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pprq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/process_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// process_priority_ready_queue
// Ready queue of process entries sorted by priority, highest first; equal
// priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | accepted when
//  in_ch    | in  | req_type, proc_id, proc_priority         | valid && ready
//  out_ch   | out | out_id, out_priority, status, occupancy  | valid && ready
//
// entries live in a circular buffer in one ram; a remove reads the head slot
// and advances the head. an insert walks from the tail toward the head, moving
// each lower-priority entry up one slot, and writes the new entry into the
// slot where it stops. full inserts and empty removes do not touch the ram.
// reset clears state, head, tail, count and the output valid; the ram is not cleared.
// a stalled result waits in the output register; the next request is taken
// meanwhile and its result holds until the register frees.
// ----------------------------------------------------------------------------
module process_priority_ready_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pprq_in_if.sink    in_ch,
  pprq_out_if.source out_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = pprq_pkg::ID_W + PRIO_BITS;
  localparam int OW = pprq_pkg::OCC_W;
  localparam int PIN_EXT = pprq_pkg::PIN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;

  logic [pprq_pkg::ID_W-1:0] new_id_r, new_id_nxt;
  logic [PRIO_BITS-1:0]      new_prio_r, new_prio_nxt;

  logic [pprq_pkg::ID_W-1:0]  res_id_r, res_id_nxt;
  logic [pprq_pkg::PIN_W-1:0] res_prio_r, res_prio_nxt;
  pprq_pkg::status_t          res_stat_r, res_stat_nxt;
  logic [pprq_pkg::OCC_W-1:0] res_occ_r, res_occ_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [pprq_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic [pprq_pkg::PIN_W-1:0] out_prio_r, out_prio_nxt;
  pprq_pkg::status_t          out_stat_r, out_stat_nxt;
  logic [pprq_pkg::OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [pprq_pkg::ID_W-1:0]        rd_id;
  logic [PRIO_BITS-1:0]             rd_prio;
  logic [PRIO_BITS+PIN_EXT-1:0]     prio_in_ext;
  logic [PRIO_BITS+PIN_EXT-1:0]     prio_out_ext;
  logic [CW:0]                      count_inc;
  logic [CW:0]                      count_dec;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  pprq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id   = ram_rdata[EW-1 -: pprq_pkg::ID_W];
  assign rd_prio = ram_rdata[PRIO_BITS-1:0];

  // priority cut or widened to the stored width, and back to 8 bits
  assign prio_in_ext  = {{PRIO_BITS{1'b0}}, in_ch.proc_priority};
  assign prio_out_ext = {{PIN_EXT{1'b0}}, rd_prio};

  assign count_inc = {1'b0, count_r} + 1'b1;
  assign count_dec = {1'b0, count_r} - 1'b1;

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_id       = out_id_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.status       = out_stat_r;
  assign out_ch.occupancy    = out_occ_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    new_id_nxt    = new_id_r;
    new_prio_nxt  = new_prio_r;
    res_id_nxt    = res_id_r;
    res_prio_nxt  = res_prio_r;
    res_stat_nxt  = res_stat_r;
    res_occ_nxt   = res_occ_r;
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_prio_nxt  = out_prio_r;
    out_stat_nxt  = out_stat_r;
    out_occ_nxt   = out_occ_r;
    ram_we        = 1'b0;
    ram_waddr     = wptr_r;
    ram_wdata     = {new_id_r, new_prio_r};
    ram_raddr     = rptr_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          new_id_nxt   = in_ch.proc_id;
          new_prio_nxt = prio_in_ext[PRIO_BITS-1:0];
          res_id_nxt   = '0;
          res_prio_nxt = '0;
          res_occ_nxt  = OW'(count_r);
          if (in_ch.req_type == pprq_pkg::REQ_INSERT) begin
            if (count_r >= CW'(QUEUE_DEPTH)) begin
              res_stat_nxt = pprq_pkg::ST_FULL;
              state_nxt    = S_DONE;
            end else begin
              walk_nxt  = count_r;
              wptr_nxt  = tail_r;
              rptr_nxt  = ptr_dec(tail_r);
              state_nxt = S_READ;
            end
          end else begin
            if (count_r == '0) begin
              res_stat_nxt = pprq_pkg::ST_EMPTY;
              state_nxt    = S_DONE;
            end else begin
              ram_raddr = head_r;
              state_nxt = S_POP;
            end
          end
        end
      end

      S_READ: begin
        if (walk_r == '0) begin
          // reached the head: new entry goes in front
          ram_we       = 1'b1;
          tail_nxt     = ptr_inc(tail_r);
          count_nxt    = count_inc[CW-1:0];
          res_stat_nxt = pprq_pkg::ST_OK;
          res_occ_nxt  = OW'(count_inc);
          state_nxt    = S_DONE;
        end else begin
          ram_raddr = rptr_r;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        ram_we = 1'b1;
        if (rd_prio >= new_prio_r) begin
          tail_nxt     = ptr_inc(tail_r);
          count_nxt    = count_inc[CW-1:0];
          res_stat_nxt = pprq_pkg::ST_OK;
          res_occ_nxt  = OW'(count_inc);
          state_nxt    = S_DONE;
        end else begin
          // move the lower-priority entry up one slot
          ram_wdata = ram_rdata;
          wptr_nxt  = rptr_r;
          rptr_nxt  = ptr_dec(rptr_r);
          walk_nxt  = walk_r - 1'b1;
          state_nxt = S_READ;
        end
      end

      S_POP: begin
        res_id_nxt   = rd_id;
        res_prio_nxt = prio_out_ext[pprq_pkg::PIN_W-1:0];
        res_stat_nxt = pprq_pkg::ST_OK;
        res_occ_nxt  = OW'(count_dec);
        head_nxt     = ptr_inc(head_r);
        count_nxt    = count_dec[CW-1:0];
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_prio_nxt  = res_prio_r;
          out_stat_nxt  = res_stat_r;
          out_occ_nxt   = res_occ_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r     <= walk_nxt;
    wptr_r     <= wptr_nxt;
    rptr_r     <= rptr_nxt;
    new_id_r   <= new_id_nxt;
    new_prio_r <= new_prio_nxt;
    res_id_r   <= res_id_nxt;
    res_prio_r <= res_prio_nxt;
    res_stat_r <= res_stat_nxt;
    res_occ_r  <= res_occ_nxt;
    out_id_r   <= out_id_nxt;
    out_prio_r <= out_prio_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

endmodule

// ===== tb/tb_process_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// tb_process_priority_ready_queue
// Self-checking bench for the priority ready queue. Requests are queued up
// front, then driven with random sender gaps and receiver stalls. Each accepted
// word runs through a local sorted-list model, and results are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_process_priority_ready_queue;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_BITS   = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 48;
  localparam int PHASE_WORDS = 300;
  localparam int ID_W        = pprq_pkg::ID_W;
  localparam int PIN_W       = pprq_pkg::PIN_W;
  localparam int OCC_W       = pprq_pkg::OCC_W;

  typedef struct {
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [PIN_W-1:0] prio;
  } request_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PIN_W-1:0]  prio;
    pprq_pkg::status_t status;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pprq_in_if  in_if ();
  pprq_out_if out_if ();

  process_priority_ready_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_BITS   (PRIO_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #6 clk = ~clk;

  // local copy of the sorted list, slot 0 is the head
  logic [ID_W-1:0]  ready_id   [QUEUE_DEPTH];
  logic [PIN_W-1:0] ready_prio [QUEUE_DEPTH];
  int               ready_count;

  request_t      request_q [$];
  queue_result_t due_q [$];

  int words_queued;
  int words_taken;
  int shadow_count;
  int sender_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int cycle_count;

  function automatic queue_result_t apply_request(logic kind, logic [ID_W-1:0] id,
                                                  logic [PIN_W-1:0] prio_in);
    queue_result_t    res;
    logic [PIN_W-1:0] prio;
    int               pos;
    prio       = prio_in & PIN_W'((64'd1 << PRIO_BITS) - 64'd1);
    res.id     = '0;
    res.prio   = '0;
    res.status = pprq_pkg::ST_OK;
    if (kind == pprq_pkg::REQ_INSERT) begin
      if (ready_count >= QUEUE_DEPTH) begin
        res.status = pprq_pkg::ST_FULL;
      end else begin
        pos = 0;
        // goes behind every entry of equal or higher priority
        while (pos < ready_count && ready_prio[pos] >= prio) pos++;
        for (int i = ready_count; i > pos; i--) begin
          ready_id[i]   = ready_id[i-1];
          ready_prio[i] = ready_prio[i-1];
        end
        ready_id[pos]   = id;
        ready_prio[pos] = prio;
        ready_count++;
      end
    end else begin
      if (ready_count == 0) begin
        res.status = pprq_pkg::ST_EMPTY;
      end else begin
        res.id   = ready_id[0];
        res.prio = ready_prio[0];
        for (int i = 1; i < ready_count; i++) begin
          ready_id[i-1]   = ready_id[i];
          ready_prio[i-1] = ready_prio[i];
        end
        ready_count--;
      end
    end
    res.occ = ready_count[OCC_W-1:0];
    return res;
  endfunction

  task automatic push_request(logic kind, logic [ID_W-1:0] id,
                              logic [PIN_W-1:0] prio);
    request_t r;
    r.kind = kind;
    r.id   = id;
    r.prio = prio;
    request_q.push_back(r);
    words_queued++;
    if (kind == pprq_pkg::REQ_INSERT && shadow_count < QUEUE_DEPTH) shadow_count++;
    if (kind == pprq_pkg::REQ_REMOVE && shadow_count > 0) shadow_count--;
  endtask

  // bursts that lean toward filling or draining, or stay balanced, so both full and empty get hit
  task automatic queue_random_words(int n);
    int               burst;
    int               insert_pct;
    int               sel;
    logic [PIN_W-1:0] prio;
    burst      = 0;
    insert_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(40, 5);
        sel   = $urandom_range(2);
        insert_pct = (sel == 0) ? 85 : (sel == 1) ? 15 : 50;
      end
      burst--;
      sel = $urandom_range(99);
      if (sel < 45)      prio = PIN_W'($urandom_range(3));
      else if (sel < 52) prio = '0;
      else if (sel < 59) prio = '1;
      else               prio = PIN_W'($urandom_range(255));
      push_request(($urandom_range(99) < insert_pct) ? pprq_pkg::REQ_INSERT
                                                     : pprq_pkg::REQ_REMOVE,
                   ID_W'($urandom_range(255)), prio);
    end
  endtask

  task automatic wait_all_done();
    while (words_taken != words_queued || due_q.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    request_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        due_q.push_back(apply_request(in_if.req_type, in_if.proc_id,
                                      in_if.proc_priority));
        words_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = request_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.req_type      <= nxt.kind;
          in_if.proc_id       <= nxt.id;
          in_if.proc_priority <= nxt.prio;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_proc
    queue_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word id=%0d prio=%0d status=%0d occ=%0d", $realtime,
                     out_if.out_id, out_if.out_priority, out_if.status, out_if.occupancy);
        end else begin
          want = due_q.pop_front();
          if (out_if.out_id !== want.id || out_if.out_priority !== want.prio ||
              out_if.status !== want.status || out_if.occupancy !== want.occ) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp id=%0d prio=%0d status=%0d occ=%0d, ",
                        "got id=%0d prio=%0d status=%0d occ=%0d"},
                       $realtime, want.id, want.prio, want.status, want.occ,
                       out_if.out_id, out_if.out_priority, out_if.status, out_if.occupancy);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("process_priority_ready_queue regression: fail");
      $finish;
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.req_type      = pprq_pkg::REQ_INSERT;
    in_if.proc_id       = '0;
    in_if.proc_priority = '0;
    out_if.ready        = 1'b0;
    rst_n           = 1'b0;
    ready_count     = 0;
    words_queued    = 0;
    words_taken     = 0;
    shadow_count    = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    mismatches      = 0;
    cycle_count     = 0;

    // directed: empty remove, fill with extremes and ties, full insert, partial drain
    push_request(pprq_pkg::REQ_REMOVE, 8'hFF, 8'hFF);
    push_request(pprq_pkg::REQ_INSERT, 8'h00, 8'h00);
    push_request(pprq_pkg::REQ_INSERT, 8'hFF, 8'hFF);
    push_request(pprq_pkg::REQ_INSERT, 8'h12, 8'h80);
    push_request(pprq_pkg::REQ_INSERT, 8'h34, 8'h80);
    push_request(pprq_pkg::REQ_INSERT, 8'h56, 8'h80);
    push_request(pprq_pkg::REQ_INSERT, 8'hAA, 8'h55);
    push_request(pprq_pkg::REQ_INSERT, 8'h55, 8'hAA);
    push_request(pprq_pkg::REQ_INSERT, 8'h01, 8'h00);
    push_request(pprq_pkg::REQ_INSERT, 8'hFE, 8'hFF);
    push_request(pprq_pkg::REQ_INSERT, 8'h80, 8'h01);
    push_request(pprq_pkg::REQ_INSERT, 8'h7F, 8'hFE);
    push_request(pprq_pkg::REQ_INSERT, 8'h0F, 8'h7F);
    push_request(pprq_pkg::REQ_INSERT, 8'hF0, 8'h81);
    push_request(pprq_pkg::REQ_INSERT, 8'h33, 8'h80);
    push_request(pprq_pkg::REQ_INSERT, 8'hCC, 8'h00);
    push_request(pprq_pkg::REQ_INSERT, 8'h99, 8'h40);
    push_request(pprq_pkg::REQ_INSERT, 8'h11, 8'hFF);
    for (int k = 0; k < 7; k++) push_request(pprq_pkg::REQ_REMOVE, 8'h00, 8'h00);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // idle patterns: none, sender gaps, receiver stalls, both light
    for (int ph = 0; ph < 4; ph++) begin
      wait_all_done();
      sender_idle_pct = (ph == 1) ? 85 : (ph == 3) ? 14 : 0;
      recv_stall_pct  = (ph == 2) ? 85 : (ph == 3) ? 14 : 0;
      queue_random_words(PHASE_WORDS);
    end

    wait_all_done();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && due_q.size() == 0) begin
      $display("process_priority_ready_queue regression: pass");
    end else begin
      $display("process_priority_ready_queue regression: fail");
    end
    $finish;
  end

endmodule
